### hdl/fct_pkg.sv
// Package for the frustum cull test block: plane packing, field widths and request kinds.
// Used by fct_plane.sv and frustum_cull_test.sv; depends on nothing else.

package fct_pkg;

    // Register file and configuration port
    localparam int PLANE_REGS     = 6;
    localparam int NUM_PLANES_DEF = 6;
    localparam int DATA_W         = 64;
    localparam int ADDR_W         = 6;
    localparam int IDX_LSB        = 3;
    localparam int IDX_W          = 3;

    // Field widths
    localparam int NORM_W  = 14;
    localparam int DIST_W  = 22;
    localparam int COORD_W = 22;
    localparam int EXT_W   = 21;

    // Plane packing: three normals from bit 0 up, distance in the top bits
    localparam int DIST_LSB   = 42;
    localparam int DIST_ALIGN = 13;

    // Widths of the product terms and of the plane sum
    localparam int PROD_W = NORM_W + COORD_W;
    localparam int MAG_W  = NORM_W;
    localparam int EXTP_W = MAG_W + EXT_W;
    localparam int SUM_W  = 40;

    // Magnitude that scales the sphere radius to the product format
    localparam logic [MAG_W-1:0] RADIUS_SCALE = MAG_W'(1 << DIST_ALIGN);

    typedef logic signed [NORM_W-1:0]  norm_t;
    typedef logic signed [DIST_W-1:0]  dist_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic        [EXT_W-1:0]   ext_t;
    typedef logic        [DATA_W-1:0]  plane_t;

    typedef enum logic [1:0] {
        REQ_POINT  = 2'd0,
        REQ_SPHERE = 2'd1,
        REQ_CUBE   = 2'd2,
        REQ_BOX    = 2'd3
    } req_kind_t;

endpackage

### hdl/fct_plane.sv
// One plane lane: registered products of the request against one plane, then the
// signed sum and its sign test. Depends on fct_pkg.

module fct_plane
(
    input  logic                      clk,
    input  logic                      load,
    input  fct_pkg::plane_t           plane,
    input  fct_pkg::req_kind_t        kind,
    input  fct_pkg::coord_t           cx,
    input  fct_pkg::coord_t           cy,
    input  fct_pkg::coord_t           cz,
    input  fct_pkg::ext_t             ex,
    input  fct_pkg::ext_t             ey,
    input  fct_pkg::ext_t             ez,
    output logic                      fail
);

    fct_pkg::norm_t nx;
    fct_pkg::norm_t ny;
    fct_pkg::norm_t nz;
    fct_pkg::dist_t plane_dist;

    logic signed [fct_pkg::NORM_W:0]   nx_wide;
    logic signed [fct_pkg::NORM_W:0]   ny_wide;
    logic signed [fct_pkg::NORM_W:0]   nz_wide;
    logic signed [fct_pkg::NORM_W:0]   nx_abs;
    logic signed [fct_pkg::NORM_W:0]   ny_abs;
    logic signed [fct_pkg::NORM_W:0]   nz_abs;
    logic [fct_pkg::MAG_W-1:0]         mag_x;
    logic [fct_pkg::MAG_W-1:0]         mag_y;
    logic [fct_pkg::MAG_W-1:0]         mag_z;

    logic signed [fct_pkg::PROD_W-1:0] prod_x_next;
    logic signed [fct_pkg::PROD_W-1:0] prod_y_next;
    logic signed [fct_pkg::PROD_W-1:0] prod_z_next;
    logic [fct_pkg::EXTP_W-1:0]        extp_x_next;
    logic [fct_pkg::EXTP_W-1:0]        extp_y_next;
    logic [fct_pkg::EXTP_W-1:0]        extp_z_next;

    logic signed [fct_pkg::PROD_W-1:0] prod_x_reg;
    logic signed [fct_pkg::PROD_W-1:0] prod_y_reg;
    logic signed [fct_pkg::PROD_W-1:0] prod_z_reg;
    logic [fct_pkg::EXTP_W-1:0]        extp_x_reg;
    logic [fct_pkg::EXTP_W-1:0]        extp_y_reg;
    logic [fct_pkg::EXTP_W-1:0]        extp_z_reg;

    logic signed [fct_pkg::DIST_W+fct_pkg::DIST_ALIGN-1:0] dist_scaled;
    logic signed [fct_pkg::SUM_W-1:0]                      sum;

    // Unpack the plane.
    assign nx         = plane[fct_pkg::NORM_W-1:0];
    assign ny         = plane[2*fct_pkg::NORM_W-1:fct_pkg::NORM_W];
    assign nz         = plane[3*fct_pkg::NORM_W-1:2*fct_pkg::NORM_W];
    assign plane_dist = plane[fct_pkg::DIST_LSB+fct_pkg::DIST_W-1:fct_pkg::DIST_LSB];

    // Normal magnitudes; the most negative normal still fits unsigned.
    assign nx_wide = (fct_pkg::NORM_W+1)'(nx);
    assign ny_wide = (fct_pkg::NORM_W+1)'(ny);
    assign nz_wide = (fct_pkg::NORM_W+1)'(nz);
    assign nx_abs  = nx_wide[fct_pkg::NORM_W] ? -nx_wide : nx_wide;
    assign ny_abs  = ny_wide[fct_pkg::NORM_W] ? -ny_wide : ny_wide;
    assign nz_abs  = nz_wide[fct_pkg::NORM_W] ? -nz_wide : nz_wide;

    // Margin weights: a sphere adds its scaled radius on one axis, a cube or box
    // pushes every axis toward the normal, and a point adds nothing.
    always_comb
    begin
        case (kind)
            fct_pkg::REQ_POINT:
            begin
                mag_x = '0;
                mag_y = '0;
                mag_z = '0;
            end
            fct_pkg::REQ_SPHERE:
            begin
                mag_x = fct_pkg::RADIUS_SCALE;
                mag_y = '0;
                mag_z = '0;
            end
            default:
            begin
                mag_x = nx_abs[fct_pkg::MAG_W-1:0];
                mag_y = ny_abs[fct_pkg::MAG_W-1:0];
                mag_z = nz_abs[fct_pkg::MAG_W-1:0];
            end
        endcase
    end

    // Products, all in parallel.
    assign prod_x_next = fct_pkg::PROD_W'(nx) * fct_pkg::PROD_W'(cx);
    assign prod_y_next = fct_pkg::PROD_W'(ny) * fct_pkg::PROD_W'(cy);
    assign prod_z_next = fct_pkg::PROD_W'(nz) * fct_pkg::PROD_W'(cz);
    assign extp_x_next = fct_pkg::EXTP_W'(mag_x) * fct_pkg::EXTP_W'(ex);
    assign extp_y_next = fct_pkg::EXTP_W'(mag_y) * fct_pkg::EXTP_W'(ey);
    assign extp_z_next = fct_pkg::EXTP_W'(mag_z) * fct_pkg::EXTP_W'(ez);

    // Product registers.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            prod_z_reg <= prod_z_next;
            extp_x_reg <= extp_x_next;
            extp_y_reg <= extp_y_next;
            extp_z_reg <= extp_z_next;
        end
    end

    // Plane value plus margin; the request fails this plane when it is negative.
    assign dist_scaled = {plane_dist, {fct_pkg::DIST_ALIGN{1'b0}}};
    assign sum = fct_pkg::SUM_W'(dist_scaled)
               + fct_pkg::SUM_W'(prod_x_reg)
               + fct_pkg::SUM_W'(prod_y_reg)
               + fct_pkg::SUM_W'(prod_z_reg)
               + $signed({{(fct_pkg::SUM_W-fct_pkg::EXTP_W){1'b0}}, extp_x_reg})
               + $signed({{(fct_pkg::SUM_W-fct_pkg::EXTP_W){1'b0}}, extp_y_reg})
               + $signed({{(fct_pkg::SUM_W-fct_pkg::EXTP_W){1'b0}}, extp_z_reg});

    assign fail = sum[fct_pkg::SUM_W-1];

endmodule

### hdl/frustum_cull_test.sv
// Top level of the frustum cull test: plane registers on an APB-style port and a
// three-register pipeline over one fct_plane lane per tested plane. Depends on fct_pkg.
//
//  Channel   Handshake                 Payload
//  -------   ------------------------  -----------------------------------------
//  request   in_valid / in_ready       req_type, center_x/y/z, extent_x/y/z
//  result    out_valid / out_ready     visible
//  config    psel penable pwrite pready paddr, pwdata, prdata (64-bit planes)
//
// One request per cycle enters while in_ready is high; the input register loads it at the
// accepting edge, and it passes on through the product registers in every plane lane to
// the result register.
// rst_n clears the pipeline valid flags and all planes, so every request passes.
// A stalled result holds the output register; requests keep entering until the
// input and product registers are full, and in_ready drops only then.

module frustum_cull_test
#(
    parameter int NUM_PLANES = fct_pkg::NUM_PLANES_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fct_pkg::ADDR_W-1:0]   paddr,
    input  logic [fct_pkg::DATA_W-1:0]   pwdata,
    output logic [fct_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,

    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   req_type,
    input  logic signed [fct_pkg::COORD_W-1:0] center_x,
    input  logic signed [fct_pkg::COORD_W-1:0] center_y,
    input  logic signed [fct_pkg::COORD_W-1:0] center_z,
    input  logic [fct_pkg::EXT_W-1:0]    extent_x,
    input  logic [fct_pkg::EXT_W-1:0]    extent_y,
    input  logic [fct_pkg::EXT_W-1:0]    extent_z,

    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         visible
);

    fct_pkg::plane_t            plane_reg [fct_pkg::PLANE_REGS];
    logic [fct_pkg::IDX_W-1:0]  reg_idx;
    logic                       reg_write;

    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic                       s2_valid_reg;
    logic                       s2_valid_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       visible_reg;
    logic                       visible_next;
    logic                       s1_adv;
    logic                       s2_adv;
    logic                       in_take;

    fct_pkg::req_kind_t         kind_reg;
    fct_pkg::coord_t            cx_reg;
    fct_pkg::coord_t            cy_reg;
    fct_pkg::coord_t            cz_reg;
    fct_pkg::ext_t              ex_reg;
    fct_pkg::ext_t              ey_reg;
    fct_pkg::ext_t              ez_reg;
    fct_pkg::ext_t              ey_next;
    fct_pkg::ext_t              ez_next;
    logic                       is_box;

    logic [NUM_PLANES-1:0]      plane_fail;

    // Configuration port: registers at 8-byte steps, writes above the last are dropped.
    assign pready    = 1'b1;
    assign reg_idx   = paddr[fct_pkg::IDX_LSB+fct_pkg::IDX_W-1:fct_pkg::IDX_LSB];
    assign reg_write = psel && penable && pwrite
                       && (reg_idx < fct_pkg::IDX_W'(fct_pkg::PLANE_REGS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fct_pkg::PLANE_REGS; i++)
            begin
                plane_reg[i] <= '0;
            end
        end
        else if (reg_write)
        begin
            plane_reg[reg_idx] <= pwdata;
        end
    end

    always_comb
    begin
        if (reg_idx < fct_pkg::IDX_W'(fct_pkg::PLANE_REGS))
        begin
            prdata = plane_reg[reg_idx];
        end
        else
        begin
            prdata = '0;
        end
    end

    // Pipeline flow: each stage moves when the next one is empty or moving.
    assign s2_adv   = !out_valid_reg || out_ready;
    assign s1_adv   = !s2_valid_reg || s2_adv;
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_take  = in_valid && in_ready;

    // Only a box has its own y and z half sizes; the other kinds reuse extent_x.
    assign is_box  = (req_type == fct_pkg::REQ_BOX);
    assign ey_next = is_box ? extent_y : extent_x;
    assign ez_next = is_box ? extent_z : extent_x;

    // Input register.
    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            kind_reg <= fct_pkg::req_kind_t'(req_type);
            cx_reg   <= center_x;
            cy_reg   <= center_y;
            cz_reg   <= center_z;
            ex_reg   <= extent_x;
            ey_reg   <= ey_next;
            ez_reg   <= ez_next;
        end
    end

    // One lane per tested plane; planes beyond NUM_PLANES are only stored.
    for (genvar p = 0; p < NUM_PLANES; p++)
    begin : g_lane
        fct_plane u_plane
        (
            .clk   (clk),
            .load  (s1_adv),
            .plane (plane_reg[p]),
            .kind  (kind_reg),
            .cx    (cx_reg),
            .cy    (cy_reg),
            .cz    (cz_reg),
            .ex    (ex_reg),
            .ey    (ey_reg),
            .ez    (ez_reg),
            .fail  (plane_fail[p])
        );
    end

    // Next-state logic for the valid flags and the result.
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s2_valid_next  = s2_valid_reg;
        out_valid_next = out_valid_reg;
        visible_next   = visible_reg;
        if (in_ready)
        begin
            s1_valid_next = in_take;
        end
        if (s1_adv)
        begin
            s2_valid_next = s1_valid_reg;
        end
        if (s2_adv)
        begin
            out_valid_next = s2_valid_reg;
            visible_next   = ~|plane_fail;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        visible_reg <= visible_next;
    end

    assign out_valid = out_valid_reg;
    assign visible   = visible_reg;

endmodule

### bench/testbench.sv
// Self-checking bench for frustum_cull_test: plane registers written over APB, culling
// requests streamed with random gaps, and every visible flag checked. Depends on fct_pkg.

module testbench;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 12;
    localparam int IDLE_PERCENT   = 17;
    localparam int PIPE_LATENCY   = 3;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_REQUESTS = 240;
    localparam int STEADY_PHASE   = 3;
    localparam int SPARE_REG_LO   = fct_pkg::PLANE_REGS;
    localparam int SPARE_REG_HI   = fct_pkg::PLANE_REGS + 1;
    localparam int AXES           = 3;

    // One culling request as driven onto the ports.
    typedef struct {
        fct_pkg::req_kind_t kind;
        fct_pkg::coord_t    cx;
        fct_pkg::coord_t    cy;
        fct_pkg::coord_t    cz;
        fct_pkg::ext_t      ex;
        fct_pkg::ext_t      ey;
        fct_pkg::ext_t      ez;
    } cull_req_t;

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [fct_pkg::ADDR_W-1:0] paddr;
    logic [fct_pkg::DATA_W-1:0] pwdata;
    logic [fct_pkg::DATA_W-1:0] prdata;
    logic                       pready;
    logic                       in_valid;
    logic                       in_ready;
    logic [1:0]                 req_type;
    fct_pkg::coord_t            center_x;
    fct_pkg::coord_t            center_y;
    fct_pkg::coord_t            center_z;
    fct_pkg::ext_t              extent_x;
    fct_pkg::ext_t              extent_y;
    fct_pkg::ext_t              extent_z;
    logic                       out_valid;
    logic                       out_ready;
    logic                       visible;

    cull_req_t       pending;
    fct_pkg::plane_t plane_shadow [fct_pkg::PLANE_REGS];
    bit              visible_expected [$];
    int              failures;
    int              cycle_count;
    bit              steady_flow;

    frustum_cull_test DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .center_x  (center_x),
        .center_y  (center_y),
        .center_z  (center_z),
        .extent_x  (extent_x),
        .extent_y  (extent_y),
        .extent_z  (extent_z),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .visible   (visible)
    );

    // The request ports follow the pending request.
    assign req_type = pending.kind;
    assign center_x = pending.cx;
    assign center_y = pending.cy;
    assign center_z = pending.cz;
    assign extent_x = pending.ex;
    assign extent_y = pending.ey;
    assign extent_z = pending.ez;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Run guard: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: cycle limit reached", $time);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Pack three Q1.13 normals and a Q14.8 distance into one plane register.
    function automatic fct_pkg::plane_t pack_plane(fct_pkg::norm_t nx, fct_pkg::norm_t ny,
                                                   fct_pkg::norm_t nz, fct_pkg::dist_t d);
        return {d, nz, ny, nx};
    endfunction

    // Visibility of one request against the shadow planes, in exact 64-bit sums.
    function automatic bit predict_visible(cull_req_t r);
        longint         c [AXES];
        longint         e [AXES];
        longint         n [AXES];
        longint         v;
        longint         best;
        fct_pkg::norm_t nv;
        fct_pkg::dist_t dv;
        bit             fail;
        bit             vis;
        vis  = 1'b1;
        c[0] = longint'(r.cx);
        c[1] = longint'(r.cy);
        c[2] = longint'(r.cz);
        e[0] = longint'(r.ex);
        e[1] = (r.kind == fct_pkg::REQ_BOX) ? longint'(r.ey) : e[0];
        e[2] = (r.kind == fct_pkg::REQ_BOX) ? longint'(r.ez) : e[0];
        for (int k = 0; k < fct_pkg::NUM_PLANES_DEF; k++)
        begin
            dv = plane_shadow[k][fct_pkg::DIST_LSB +: fct_pkg::DIST_W];
            v  = longint'(dv) * (longint'(1) << fct_pkg::DIST_ALIGN);
            for (int a = 0; a < AXES; a++)
            begin
                nv   = plane_shadow[k][fct_pkg::NORM_W * a +: fct_pkg::NORM_W];
                n[a] = longint'(nv);
                v   += n[a] * c[a];
            end
            case (r.kind)
                fct_pkg::REQ_POINT:
                    fail = v < 0;
                fct_pkg::REQ_SPHERE:
                    fail = v < -(e[0] * (longint'(1) << fct_pkg::DIST_ALIGN));
                default:
                begin
                    // The corner pushed furthest along the normal decides.
                    best = v;
                    for (int a = 0; a < AXES; a++)
                        best += ((n[a] < 0) ? -n[a] : n[a]) * e[a];
                    fail = best < 0;
                end
            endcase
            if (fail)
                vis = 1'b0;
        end
        return vis;
    endfunction

    // Every accepted request queues its expected visible flag.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            visible_expected.push_back(predict_visible(pending));
    end

    // Every accepted result is compared with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (visible_expected.size() == 0)
            begin
                $display("%0t: result with no request pending, expected none, actual %0b",
                         $time, visible);
                failures++;
            end
            else
            begin
                if (visible !== visible_expected[0])
                begin
                    $display("%0t: visible mismatch, expected %0b, actual %0b",
                             $time, visible_expected[0], visible);
                    failures++;
                end
                void'(visible_expected.pop_front());
            end
        end
    end

    // The result side stalls at random except in steady phases.
    always @(negedge clk)
    begin
        out_ready = steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // One APB write; the register takes the value at the access edge and reads back.
    task automatic write_plane(input int idx, input fct_pkg::plane_t value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = fct_pkg::ADDR_W'(idx << fct_pkg::IDX_LSB);
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (idx < fct_pkg::PLANE_REGS)
            plane_shadow[idx] = value;
        @(negedge clk);
        if (idx < fct_pkg::PLANE_REGS && prdata !== value)
        begin
            $display("%0t: plane %0d readback mismatch, expected %h, actual %h",
                     $time, idx, value, prdata);
            failures++;
        end
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Send one request, called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input fct_pkg::req_kind_t kind, input fct_pkg::coord_t cx,
                                input fct_pkg::coord_t cy, input fct_pkg::coord_t cz,
                                input fct_pkg::ext_t ex, input fct_pkg::ext_t ey,
                                input fct_pkg::ext_t ez);
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        pending.kind = kind;
        pending.cx   = cx;
        pending.cy   = cy;
        pending.cz   = cz;
        pending.ex   = ex;
        pending.ey   = ey;
        pending.ez   = ez;
        in_valid     = 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // Drain the pipeline so the planes may be rewritten.
    task automatic wait_idle();
        in_valid = 1'b0;
        while (visible_expected.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 2) @(negedge clk);
    endtask

    // Shift amount that favors full-width values but also reaches small ones.
    function automatic int random_shift(int max_shift);
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, max_shift);
    endfunction

    task automatic send_random_request();
        fct_pkg::coord_t c [AXES];
        fct_pkg::ext_t   e [AXES];
        for (int a = 0; a < AXES; a++)
        begin
            c[a] = fct_pkg::coord_t'($urandom) >>> random_shift(fct_pkg::COORD_W - 1);
            e[a] = fct_pkg::ext_t'($urandom) >> random_shift(fct_pkg::EXT_W - 1);
        end
        send_request(fct_pkg::req_kind_t'($urandom_range(0, 3)), c[0], c[1], c[2],
                     e[0], e[1], e[2]);
    endtask

    // Random plane, mostly with a positive distance so both outcomes occur.
    function automatic fct_pkg::plane_t random_plane();
        fct_pkg::norm_t n [AXES];
        fct_pkg::dist_t d;
        if ($urandom_range(0, 9) == 0)
            return '0;
        for (int a = 0; a < AXES; a++)
            n[a] = fct_pkg::norm_t'($urandom) >>> random_shift(fct_pkg::NORM_W - 1);
        d = fct_pkg::dist_t'($urandom) >> 1;
        d = d >> $urandom_range(0, 10);
        if ($urandom_range(0, 99) < 15)
            d = -d;
        return pack_plane(n[0], n[1], n[2], d);
    endfunction

    // All planes are zero after reset, so even extreme requests pass.
    task automatic test_reset_planes();
        send_request(fct_pkg::REQ_POINT, -2097152, -2097152, -2097152, 0, 0, 0);
        send_request(fct_pkg::REQ_SPHERE, 2097151, 2097151, 2097151, 2097151, 2097151,
                     2097151);
        send_request(fct_pkg::REQ_CUBE, -2097152, 2097151, 0, 2097151, 0, 0);
        send_request(fct_pkg::REQ_BOX, 2097151, -2097152, -1, 0, 2097151, 0);
        wait_idle();
    endtask

    // A box frustum of half size 1024 on every axis, probed at its walls.
    task automatic test_bounded_box();
        write_plane(0, pack_plane(4096, 0, 0, 512));
        write_plane(1, pack_plane(-4096, 0, 0, 512));
        write_plane(2, pack_plane(0, 4096, 0, 512));
        write_plane(3, pack_plane(0, -4096, 0, 512));
        write_plane(4, pack_plane(0, 0, 4096, 512));
        write_plane(5, pack_plane(0, 0, -4096, 512));
        send_request(fct_pkg::REQ_POINT, 0, 0, 0, 2097151, 2097151, 2097151);
        send_request(fct_pkg::REQ_POINT, 1024, 0, 0, 0, 0, 0);
        send_request(fct_pkg::REQ_POINT, 1025, 0, 0, 0, 0, 0);
        send_request(fct_pkg::REQ_POINT, 0, 0, -1025, 0, 0, 0);
        send_request(fct_pkg::REQ_SPHERE, 1030, 0, 0, 3, 2097151, 2097151);
        send_request(fct_pkg::REQ_SPHERE, 1030, 0, 0, 2, 0, 0);
        send_request(fct_pkg::REQ_CUBE, 1100, 1100, 0, 76, 0, 0);
        send_request(fct_pkg::REQ_CUBE, 1100, 0, 0, 75, 2097151, 2097151);
        send_request(fct_pkg::REQ_BOX, 1100, 0, 0, 76, 0, 0);
        send_request(fct_pkg::REQ_BOX, 1100, 1100, 0, 76, 75, 2097151);
        wait_idle();
    endtask

    // Zero-normal planes and writes to indexes past the register file.
    task automatic test_degenerate_planes();
        write_plane(5, pack_plane(0, 0, 0, -1));
        send_request(fct_pkg::REQ_POINT, 0, 0, 0, 0, 0, 0);
        send_request(fct_pkg::REQ_SPHERE, 0, 0, 0, 0, 0, 0);
        send_request(fct_pkg::REQ_SPHERE, 0, 0, 0, 1, 0, 0);
        send_request(fct_pkg::REQ_CUBE, 0, 0, 0, 2097151, 0, 0);
        wait_idle();
        write_plane(5, pack_plane(0, 0, 0, 0));
        write_plane(SPARE_REG_LO, '1);
        write_plane(SPARE_REG_HI, '1);
        send_request(fct_pkg::REQ_BOX, 0, 0, 0, 2097151, 2097151, 2097151);
        send_request(fct_pkg::REQ_POINT, 0, 0, 0, 0, 0, 0);
        wait_idle();
    endtask

    // Planes at the corners of the register range against extreme requests.
    task automatic test_extreme_planes();
        write_plane(0, pack_plane(8191, 8191, 8191, 2097151));
        write_plane(1, pack_plane(-8192, -8192, -8192, 2097151));
        write_plane(2, pack_plane(8191, -8192, 0, -2097152));
        write_plane(3, '0);
        write_plane(4, '0);
        write_plane(5, '0);
        send_request(fct_pkg::REQ_POINT, 2097151, 2097151, 2097151, 0, 0, 0);
        send_request(fct_pkg::REQ_SPHERE, -2097152, 2097151, 0, 2097151, 0, 0);
        send_request(fct_pkg::REQ_CUBE, 2097151, -2097152, 2097151, 2097151, 0, 0);
        send_request(fct_pkg::REQ_BOX, -2097152, -2097152, -2097152, 2097151, 2097151,
                     2097151);
        send_request(fct_pkg::REQ_BOX, 2097151, -2097152, 0, 2097151, 2097151, 0);
        wait_idle();
    endtask

    // Random frustums, each followed by a stream of random requests.
    task automatic test_random_frustums();
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            for (int k = 0; k < fct_pkg::PLANE_REGS; k++)
                write_plane(k, random_plane());
            steady_flow = (phase == STEADY_PHASE);
            repeat (PHASE_REQUESTS) send_random_request();
            steady_flow = 1'b0;
            wait_idle();
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        pending.kind = fct_pkg::REQ_POINT;
        pending.cx   = '0;
        pending.cy   = '0;
        pending.cz   = '0;
        pending.ex   = '0;
        pending.ey   = '0;
        pending.ez   = '0;
        failures     = 0;
        cycle_count  = 0;
        steady_flow  = 1'b0;
        for (int k = 0; k < fct_pkg::PLANE_REGS; k++)
            plane_shadow[k] = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_planes();
        test_bounded_box();
        test_degenerate_planes();
        test_extreme_planes();
        test_random_frustums();

        repeat (PIPE_LATENCY * 4) @(negedge clk);
        if (visible_expected.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, visible_expected.size());
            failures++;
        end
        if (failures == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
